// ===== sv/brc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brc_pkg
// Types, constants and state encodings shared by the request checker.
// ----------------------------------------------------------------------------
package brc_pkg;
  localparam int PROCS = 16;
  localparam int RESOURCES = 4;
  localparam int PW = $clog2(PROCS);
  localparam int RW = (RESOURCES > 1) ? $clog2(RESOURCES) : 1;
  localparam int AW = PW + RW;
  localparam int DEPTH = PROCS * RESOURCES;
  localparam logic [11:0] WORK_MAX = 12'd4095;

  typedef enum logic [1:0] {
    CMD_WR_ALLOC = 2'd0,
    CMD_WR_MAX   = 2'd1,
    CMD_WR_AVAIL = 2'd2,
    CMD_REQUEST  = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_GRANTED  = 3'd0,
    ST_EXCEEDS  = 3'd1,
    ST_WAIT     = 3'd2,
    ST_UNSAFE   = 3'd3,
    ST_INVALID  = 3'd4,
    ST_WR_DONE  = 3'd5
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHK_RD,
    S_CHK,
    S_APPLY_RD,
    S_APPLY,
    S_PROC_START,
    S_PROC_RD,
    S_PROC_CMP,
    S_PROC_ADD_RD,
    S_PROC_ADD,
    S_PASS_END,
    S_ROLLBACK_RD,
    S_ROLLBACK,
    S_DONE
  } fsm_t;

  localparam logic [0:0] ADDR_PROCS = 1'b0;
  localparam logic [0:0] ADDR_RES   = 1'b1;
endpackage

// ===== sv/brc_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brc_in_if / brc_out_if
// Valid/ready channels for commands and results.
// ----------------------------------------------------------------------------
interface brc_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [3:0] process_id;
  logic [1:0] resource_id;
  logic [7:0] write_value;
  logic [7:0] req_0;
  logic [7:0] req_1;
  logic [7:0] req_2;
  logic [7:0] req_3;
  modport source(output valid, command, process_id, resource_id, write_value,
                 req_0, req_1, req_2, req_3, input ready);
  modport sink(input valid, command, process_id, resource_id, write_value,
               req_0, req_1, req_2, req_3, output ready);
  modport monitor(input valid, ready, command, process_id, resource_id,
                  write_value, req_0, req_1, req_2, req_3);
endinterface

interface brc_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [3:0] process_echo;
  modport source(output valid, status, process_echo, input ready);
  modport sink(input valid, status, process_echo, output ready);
  modport monitor(input valid, ready, status, process_echo);
endinterface

// ===== sv/brc_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brc_ram
// Single-port synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module brc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

// ===== sv/bankers_request_check.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bankers_request_check
// Banker's algorithm request checker with table state held in RAM.
// ----------------------------------------------------------------------------
// Commands arrive on the in_ channel and each produces exactly one result on
// the out_ channel, with status and the echoed process id. A write command
// or a command for a process not in use goes straight to S_DONE, which
// registers its result in the output register. A request reads the process
// row, checks need and availability per resource, applies the grant when
// both checks pass, runs the safety check and rolls the grant back if the
// state is unsafe. The check reads each process row through the allocation
// and maximum RAMs, and at most PROCS+1 passes run. One command is handled
// at a time.
// After reset a clearing pass writes zero into all PROCS*RESOURCES entries of
// both RAMs, one a cycle, while no command is accepted. A result waits in
// the output register while the receiver stalls; no new command is taken
// until it has been transferred. The cfg_ port holds processes_in_use at
// byte address 0 and resources_in_use at byte address 4.
// ----------------------------------------------------------------------------
module bankers_request_check (
  input  logic        clk,
  input  logic        rst_n,
  brc_in_if.sink      in_ch,
  brc_out_if.source   out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  localparam int PW = brc_pkg::PW;
  localparam int RW = brc_pkg::RW;
  localparam int AW = brc_pkg::AW;
  localparam int RES = brc_pkg::RESOURCES;

  logic [4:0] procs_cfg_r;
  logic [2:0] res_cfg_r;

  assign cfg_pready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      procs_cfg_r <= 5'd16;
      res_cfg_r   <= 3'd4;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      if (cfg_paddr[2] == brc_pkg::ADDR_PROCS && cfg_paddr[1:0] == 2'd0) begin
        procs_cfg_r <= cfg_pwdata[4:0];
      end else if (cfg_paddr[2] == brc_pkg::ADDR_RES && cfg_paddr[1:0] == 2'd0) begin
        res_cfg_r <= cfg_pwdata[2:0];
      end
    end
  end
  always_comb begin
    cfg_prdata = 32'd0;
    if (cfg_paddr[2] == brc_pkg::ADDR_PROCS) cfg_prdata[4:0] = procs_cfg_r;
    else cfg_prdata[2:0] = res_cfg_r;
  end

  // Effective counts, saturated into 1..PROCS and 1..RESOURCES.
  logic [PW:0] n_eff;
  logic [RW:0] m_eff;
  always_comb begin
    if (procs_cfg_r == 5'd0) n_eff = (PW+1)'(1);
    else if (32'(procs_cfg_r) > brc_pkg::PROCS) n_eff = (PW+1)'(brc_pkg::PROCS);
    else n_eff = (PW+1)'(procs_cfg_r);
    if (res_cfg_r == 3'd0) m_eff = (RW+1)'(1);
    else if (32'(res_cfg_r) > RES) m_eff = (RW+1)'(RES);
    else m_eff = (RW+1)'(res_cfg_r);
  end

  brc_pkg::fsm_t state_r, state_nxt;

  logic [1:0]  cmd_r;
  logic [3:0]  pid_r;
  logic [1:0]  rid_r;
  logic [7:0]  val_r;
  logic [7:0]  req_r [RES];
  logic [7:0]  avail_r [RES];
  logic [11:0] work_r [RES];
  logic [brc_pkg::PROCS-1:0] fin_r;
  logic [RW-1:0] ridx_r;
  logic [PW-1:0] pidx_r;
  logic [PW:0]   done_r;
  logic          progress_r;
  logic          fits_r;
  logic          clr_r;
  logic [AW:0]   clr_cnt_r;
  logic          ovalid_r;
  logic [2:0]    ostatus_r;
  logic [3:0]    oecho_r;

  // RAM ports.
  logic          a_we, m_we;
  logic [AW-1:0] ram_addr;
  logic [7:0]    a_wdata, m_wdata, a_rdata, m_rdata;

  brc_ram #(.WIDTH(8), .DEPTH(brc_pkg::DEPTH)) u_alloc (
    .clk(clk), .we(a_we), .addr(ram_addr), .wdata(a_wdata), .rdata(a_rdata));
  brc_ram #(.WIDTH(8), .DEPTH(brc_pkg::DEPTH)) u_max (
    .clk(clk), .we(m_we), .addr(ram_addr), .wdata(m_wdata), .rdata(m_rdata));

  logic in_xfer;
  assign in_ch.ready = (state_r == brc_pkg::S_IDLE) && !clr_r && !ovalid_r;
  assign in_xfer = in_ch.valid && in_ch.ready;

  assign out_ch.valid = ovalid_r;
  assign out_ch.status = ostatus_r;
  assign out_ch.process_echo = oecho_r;

  logic last_idx;
  logic [PW:0] pidx_ext;
  logic [RW:0] ridx_ext;
  assign ridx_ext = {1'b0, ridx_r};
  assign pidx_ext = {1'b0, pidx_r};
  assign last_idx = (ridx_ext + (RW+1)'(1)) == m_eff;

  logic signed [9:0] need_s;
  logic [7:0] req_cur, avail_cur;
  logic [11:0] work_cur;
  logic [12:0] work_sum;
  assign req_cur   = req_r[ridx_r];
  assign avail_cur = avail_r[ridx_r];
  assign work_cur  = work_r[ridx_r];
  assign need_s    = $signed({2'b00, m_rdata}) - $signed({2'b00, a_rdata});
  assign work_sum  = {1'b0, work_cur} + 13'(a_rdata);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      brc_pkg::S_IDLE: begin
        if (in_xfer) begin
          if (in_ch.command == brc_pkg::CMD_REQUEST &&
              {1'b0, in_ch.process_id} < 5'(n_eff)) state_nxt = brc_pkg::S_CHK_RD;
          else state_nxt = brc_pkg::S_DONE;
        end
      end
      brc_pkg::S_CHK_RD:  state_nxt = brc_pkg::S_CHK;
      brc_pkg::S_CHK: begin
        if (last_idx) state_nxt = brc_pkg::S_APPLY_RD;
        else state_nxt = brc_pkg::S_CHK_RD;
      end
      brc_pkg::S_APPLY_RD: begin
        if (ostatus_r != brc_pkg::ST_GRANTED || fits_r) state_nxt = brc_pkg::S_DONE;
        else state_nxt = brc_pkg::S_APPLY;
      end
      brc_pkg::S_APPLY: begin
        if (last_idx) state_nxt = brc_pkg::S_PROC_START;
        else state_nxt = brc_pkg::S_APPLY_RD;
      end
      brc_pkg::S_PROC_START: begin
        if (fin_r[pidx_r]) state_nxt = brc_pkg::S_PASS_END;
        else state_nxt = brc_pkg::S_PROC_RD;
      end
      brc_pkg::S_PROC_RD: state_nxt = brc_pkg::S_PROC_CMP;
      brc_pkg::S_PROC_CMP: begin
        if (need_s > $signed({1'b0, 1'b0, work_cur[7:0]}) && work_cur[11:8] == 4'd0)
          state_nxt = brc_pkg::S_PASS_END;
        else if (last_idx) state_nxt = brc_pkg::S_PROC_ADD_RD;
        else state_nxt = brc_pkg::S_PROC_RD;
      end
      brc_pkg::S_PROC_ADD_RD: state_nxt = brc_pkg::S_PROC_ADD;
      brc_pkg::S_PROC_ADD: begin
        if (last_idx) state_nxt = brc_pkg::S_PASS_END;
        else state_nxt = brc_pkg::S_PROC_ADD_RD;
      end
      brc_pkg::S_PASS_END: begin
        if (pidx_ext + (PW+1)'(1) < n_eff) state_nxt = brc_pkg::S_PROC_START;
        else if (progress_r) state_nxt = brc_pkg::S_PROC_START;
        else if (done_r == n_eff) state_nxt = brc_pkg::S_DONE;
        else state_nxt = brc_pkg::S_ROLLBACK_RD;
      end
      brc_pkg::S_ROLLBACK_RD: state_nxt = brc_pkg::S_ROLLBACK;
      brc_pkg::S_ROLLBACK: begin
        if (last_idx) state_nxt = brc_pkg::S_DONE;
        else state_nxt = brc_pkg::S_ROLLBACK_RD;
      end
      brc_pkg::S_DONE: state_nxt = brc_pkg::S_IDLE;
      default: state_nxt = brc_pkg::S_IDLE;
    endcase
  end

  // RAM address and write control.
  logic [PW-1:0] row;
  always_comb begin
    a_we = 1'b0;
    m_we = 1'b0;
    a_wdata = 8'd0;
    m_wdata = 8'd0;
    row = pid_r[PW-1:0];
    if (state_r == brc_pkg::S_PROC_START || state_r == brc_pkg::S_PROC_RD ||
        state_r == brc_pkg::S_PROC_CMP || state_r == brc_pkg::S_PROC_ADD_RD ||
        state_r == brc_pkg::S_PROC_ADD)
      row = pidx_r;
    ram_addr = {row, ridx_r};
    if (clr_r) begin
      ram_addr = clr_cnt_r[AW-1:0];
      a_we = 1'b1;
      m_we = 1'b1;
    end else begin
      unique case (state_r)
        brc_pkg::S_DONE: begin
          ram_addr = {pid_r[PW-1:0], rid_r[RW-1:0]};
          if (ostatus_r == brc_pkg::ST_WR_DONE && {1'b0, rid_r} < 3'(m_eff) &&
              cmd_r != brc_pkg::CMD_WR_AVAIL && cmd_r != brc_pkg::CMD_REQUEST) begin
            a_we = (cmd_r == brc_pkg::CMD_WR_ALLOC);
            m_we = (cmd_r == brc_pkg::CMD_WR_MAX);
            a_wdata = val_r;
            m_wdata = val_r;
          end
        end
        brc_pkg::S_APPLY: begin
          a_we = 1'b1;
          a_wdata = a_rdata + req_cur;
        end
        brc_pkg::S_ROLLBACK: begin
          a_we = 1'b1;
          a_wdata = a_rdata - req_cur;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= brc_pkg::S_IDLE;
      clr_r      <= 1'b1;
      clr_cnt_r  <= '0;
      ovalid_r   <= 1'b0;
      fin_r      <= '0;
      ridx_r     <= '0;
      pidx_r     <= '0;
      done_r     <= '0;
      progress_r <= 1'b0;
      fits_r     <= 1'b0;
      for (int i = 0; i < RES; i++) begin
        avail_r[i] <= 8'd0;
        work_r[i]  <= 12'd0;
      end
    end else begin
      state_r <= state_nxt;
      if (clr_r) begin
        clr_cnt_r <= clr_cnt_r + (AW+1)'(1);
        if (clr_cnt_r == (AW+1)'(brc_pkg::DEPTH - 1)) clr_r <= 1'b0;
      end
      if (out_ch.valid && out_ch.ready) ovalid_r <= 1'b0;
      unique case (state_r)
        brc_pkg::S_IDLE: begin
          if (in_xfer) begin
            cmd_r  <= in_ch.command;
            pid_r  <= in_ch.process_id;
            rid_r  <= in_ch.resource_id;
            val_r  <= in_ch.write_value;
            req_r[0] <= in_ch.req_0;
            if (RES > 1) req_r[1 % RES] <= in_ch.req_1;
            if (RES > 2) req_r[2 % RES] <= in_ch.req_2;
            if (RES > 3) req_r[3 % RES] <= in_ch.req_3;
            oecho_r <= in_ch.process_id;
            ridx_r  <= '0;
            if (in_ch.command == brc_pkg::CMD_WR_AVAIL) begin
              ostatus_r <= brc_pkg::ST_WR_DONE;
              if ({1'b0, in_ch.resource_id} < 3'(m_eff))
                avail_r[in_ch.resource_id[RW-1:0]] <= in_ch.write_value;
            end else if ({1'b0, in_ch.process_id} >= 5'(n_eff)) begin
              ostatus_r <= brc_pkg::ST_INVALID;
            end else if (in_ch.command == brc_pkg::CMD_REQUEST) begin
              ostatus_r <= brc_pkg::ST_GRANTED;
            end else begin
              ostatus_r <= brc_pkg::ST_WR_DONE;
            end
          end
        end
        brc_pkg::S_CHK: begin
          if (ostatus_r == brc_pkg::ST_GRANTED &&
              $signed({2'b00, req_cur}) > need_s) ostatus_r <= brc_pkg::ST_EXCEEDS;
          else if (ostatus_r == brc_pkg::ST_GRANTED && req_cur > avail_cur)
            fits_r <= 1'b1;
          if (last_idx) ridx_r <= '0;
          else ridx_r <= ridx_r + RW'(1);
        end
        brc_pkg::S_CHK_RD: begin
          if (ridx_r == '0) fits_r <= 1'b0;
        end
        brc_pkg::S_APPLY_RD: begin
          // Need failures win over wait, so wait is resolved here.
          if (ostatus_r == brc_pkg::ST_GRANTED && fits_r) ostatus_r <= brc_pkg::ST_WAIT;
        end
        brc_pkg::S_APPLY: begin
          avail_r[ridx_r] <= avail_cur - req_cur;
          if (last_idx) begin
            ridx_r <= '0;
            pidx_r <= '0;
            fin_r <= '0;
            done_r <= '0;
            progress_r <= 1'b0;
            for (int i = 0; i < RES; i++) begin
              work_r[i] <= (i < int'(m_eff)) ?
                12'((i == int'(ridx_r)) ? (avail_cur - req_cur) : avail_r[i]) : 12'd0;
            end
          end else begin
            ridx_r <= ridx_r + RW'(1);
          end
        end
        brc_pkg::S_PROC_START: ridx_r <= '0;
        brc_pkg::S_PROC_CMP: begin
          if (need_s > $signed({2'b00, work_cur[7:0]}) && work_cur[11:8] == 4'd0)
            ridx_r <= '0;
          else if (last_idx) ridx_r <= '0;
          else ridx_r <= ridx_r + RW'(1);
        end
        brc_pkg::S_PROC_ADD: begin
          work_r[ridx_r] <= (work_sum > 13'(brc_pkg::WORK_MAX)) ?
                            brc_pkg::WORK_MAX : work_sum[11:0];
          if (last_idx) begin
            ridx_r <= '0;
            fin_r[pidx_r] <= 1'b1;
            done_r <= done_r + (PW+1)'(1);
            progress_r <= 1'b1;
          end else begin
            ridx_r <= ridx_r + RW'(1);
          end
        end
        brc_pkg::S_PASS_END: begin
          ridx_r <= '0;
          if (pidx_ext + (PW+1)'(1) < n_eff) begin
            pidx_r <= pidx_r + PW'(1);
          end else begin
            pidx_r <= '0;
            progress_r <= 1'b0;
            if (!progress_r && done_r != n_eff) ostatus_r <= brc_pkg::ST_UNSAFE;
          end
        end
        brc_pkg::S_ROLLBACK: begin
          avail_r[ridx_r] <= avail_cur + req_cur;
          if (last_idx) ridx_r <= '0;
          else ridx_r <= ridx_r + RW'(1);
        end
        brc_pkg::S_DONE: ovalid_r <= 1'b1;
        default: begin
        end
      endcase
    end
  end
endmodule
